FILE: rtl/core/mpem_pkg.sv
// Shared widths and constants for the multichannel pulse energy meter.
// No dependencies; every other file of the block but mpem_divider uses it by scoped names.
package mpem_pkg;

   localparam int NUM_CH    = 8;    // pulse lines carried by the sample
   localparam int CH_W      = 3;    // channel number width
   localparam int LEVELS_W  = 8;    // pin_levels field
   localparam int STAMP_W   = 48;   // sample_time and period_ticks fields
   localparam int OUT_W     = 32;   // counts, energy and power fields
   localparam int RATE_W    = 16;   // pulses per kWh register
   localparam int CSR_IDX_W = 4;    // register index, wide enough to see stray writes

   localparam logic [OUT_W-1:0] SAT = {OUT_W{1'b1}};

endpackage

FILE: rtl/core/mpem_req_if.sv
// Sample channel of the pulse energy meter: valid/ready plus sample payload.
// Depends on mpem_pkg for field widths.
interface mpem_req_if;
   logic                             valid;
   logic                             ready;
   logic [mpem_pkg::LEVELS_W-1:0]    pin_levels;
   logic [mpem_pkg::STAMP_W-1:0]     sample_time;

   modport source (output valid, output pin_levels, output sample_time, input ready);
   modport sink   (input valid, input pin_levels, input sample_time, output ready);
endinterface

FILE: rtl/core/mpem_rsp_if.sv
// Result channel of the pulse energy meter: valid/ready plus one channel result.
// Depends on mpem_pkg for field widths.
interface mpem_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mpem_pkg::CH_W-1:0]        channel;
   logic [mpem_pkg::OUT_W-1:0]       pulse_count;
   logic [mpem_pkg::STAMP_W-1:0]     period_ticks;
   logic [mpem_pkg::OUT_W-1:0]       energy_wh;
   logic [mpem_pkg::OUT_W-1:0]       power_w;
   logic [mpem_pkg::OUT_W-1:0]       total_pulses;
   logic                             divide_fault;
   logic                             last_of_sample;

   modport source (output valid, output channel, output pulse_count, output period_ticks,
                   output energy_wh, output power_w, output total_pulses,
                   output divide_fault, output last_of_sample, input ready);
   modport sink   (input valid, input channel, input pulse_count, input period_ticks,
                   input energy_wh, input power_w, input total_pulses,
                   input divide_fault, input last_of_sample, output ready);
endinterface

FILE: rtl/core/mpem_csr.sv
// Rate register file: one pulses-per-kWh register per channel, write-only port.
// Depends on mpem_pkg; read back internally at the channel being worked on.
module mpem_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               we,
   input  logic [mpem_pkg::CSR_IDX_W-1:0]     index,
   input  logic [mpem_pkg::RATE_W-1:0]        wdata,
   input  logic [mpem_pkg::CH_W-1:0]          rd_ch,
   output logic [mpem_pkg::RATE_W-1:0]        rd_rate
);

   logic [mpem_pkg::RATE_W-1:0] rate_ff [mpem_pkg::NUM_CH];
   logic                        hit;

   // drop writes beyond the last register
   assign hit = we && (index[mpem_pkg::CSR_IDX_W-1:mpem_pkg::CH_W] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mpem_pkg::NUM_CH; i++) begin
            rate_ff[i] <= '0;
         end
      end else if (hit) begin
         rate_ff[index[mpem_pkg::CH_W-1:0]] <= wdata;
      end
   end

   assign rd_rate = rate_ff[rd_ch];

endmodule

FILE: rtl/core/mpem_divider.sv
// Shared restoring divider: one quotient bit per cycle for a DIVIDEND_W-bit quotient.
// Depends on nothing; done pulses in the cycle after the last step with quotient held.
module mpem_divider #(
   parameter int DIVIDEND_W = 42,
   parameter int DIVISOR_W  = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DIVIDEND_W-1:0]   dividend,
   input  logic [DIVISOR_W-1:0]    divisor,
   output logic                    busy,
   output logic                    done,
   output logic [DIVIDEND_W-1:0]   quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic [STEP_W-1:0]     step_ff,  step_in;
   logic                  done_ff,  done_in;
   logic [DIVISOR_W-1:0]  rem_ff,   rem_in;
   logic [DIVIDEND_W-1:0] quo_ff,   quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff,   dvs_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      step_in = step_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         step_in = STEP_W'(DIVIDEND_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (step_ff != '0) begin
         step_in = step_ff - 1'b1;
         rem_in  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], ge};
         done_in = (step_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (step_ff != '0);
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/core/multichannel_pulse_energy_meter_top.sv
// Multichannel pulse energy meter: edge detect, per-channel counters and a sequencer
// driving one shared divider for energy and power. Uses mpem_pkg, mpem_csr, mpem_divider.
// Per sample: latch the rising lines and scan the channels; for each rising channel the
// divider forms energy = count * 1000 / rate and power = (NUM / rate) / period. A zero
// rate saturates both, a zero period the power, with divide_fault. One sample at a time: req
// ready only when idle. Synchronous reset clears counters, pulse times, line levels, rates.
module multichannel_pulse_energy_meter_top #(
   parameter int          CHANNELS         = 8,
   parameter int unsigned TICKS_PER_SECOND = 1000000,
   parameter int          TIME_BITS        = 48,
   parameter int          COUNT_BITS       = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   mpem_req_if.sink                         req_bus,
   mpem_rsp_if.source                       rsp_bus,
   input  logic                             csr_we,
   input  logic [mpem_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mpem_pkg::RATE_W-1:0]      csr_wdata
);

   localparam int          NCH    = mpem_pkg::NUM_CH;
   localparam int          CHW    = mpem_pkg::CH_W;
   localparam int          OW     = mpem_pkg::OUT_W;
   localparam int          EW     = COUNT_BITS + 10;
   localparam logic [63:0] NUM    = 64'd3600000 * 64'(TICKS_PER_SECOND);
   localparam int          NUM_W  = $clog2(NUM + 64'd1);
   localparam int          DIVW_A = (EW > NUM_W) ? EW : NUM_W;
   localparam int          DIVW   = (DIVW_A > OW + 1) ? DIVW_A : OW + 1;
   localparam logic [DIVW-1:0] NUM_D = DIVW'(NUM);
   localparam logic [NCH:0]    MASK_X = (NCH + 1)'(1) << CHANNELS;
   localparam logic [NCH-1:0]  CH_MASK = NCH'(MASK_X - 1'b1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_ENERGY, ST_WAIT_E, ST_WAIT_N, ST_WAIT_P, ST_OUT
   } state_type;

   state_type               state_ff, state_in;
   logic [NCH-1:0]          prev_ff, prev_in;
   logic [NCH-1:0]          rise_ff, rise_in;
   logic [TIME_BITS-1:0]    time_ff, time_in;
   logic [CHW-1:0]          ch_ff, ch_in;
   logic [TIME_BITS-1:0]    last_time_ff [NCH];
   logic [TIME_BITS-1:0]    last_time_in [NCH];
   logic [COUNT_BITS-1:0]   count_ff [NCH];
   logic [COUNT_BITS-1:0]   count_in [NCH];
   logic [COUNT_BITS-1:0]   total_ff, total_in;
   logic [COUNT_BITS-1:0]   res_cnt_ff, res_cnt_in;
   logic [COUNT_BITS-1:0]   res_tot_ff, res_tot_in;
   logic [TIME_BITS-1:0]    period_ff, period_in;
   logic [OW-1:0]           energy_ff, energy_in;
   logic [OW-1:0]           power_ff, power_in;
   logic                    fault_ff, fault_in;
   logic                    last_ff, last_in;

   logic [mpem_pkg::RATE_W-1:0] rate;
   logic                    div_start;
   logic [DIVW-1:0]         div_dividend;
   logic [TIME_BITS-1:0]    div_divisor;
   logic                    div_busy;
   logic                    div_done;
   logic [DIVW-1:0]         div_quo;
   logic [OW-1:0]           div_sat;
   logic [EW-1:0]           prod;
   logic [NCH-1:0]          levels;
   logic [NCH-1:0]          rise_clr;
   logic [COUNT_BITS-1:0]   cnt_next;
   logic [COUNT_BITS-1:0]   tot_next;

   mpem_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .we      (csr_we),
      .index   (csr_index),
      .wdata   (csr_wdata),
      .rd_ch   (ch_ff),
      .rd_rate (rate)
   );

   mpem_divider #(
      .DIVIDEND_W (DIVW),
      .DIVISOR_W  (TIME_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   // count * 1000 as count * (1024 - 16 - 8)
   assign prod = (EW'(res_cnt_ff) << 10) - (EW'(res_cnt_ff) << 4) - (EW'(res_cnt_ff) << 3);
   assign div_sat  = (|div_quo[DIVW-1:OW]) ? mpem_pkg::SAT : div_quo[OW-1:0];
   assign levels   = req_bus.pin_levels[NCH-1:0] & CH_MASK;
   assign rise_clr = rise_ff & ~(NCH'(1) << ch_ff);
   assign cnt_next = count_ff[ch_ff] + 1'b1;
   assign tot_next = total_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      rise_in      = rise_ff;
      time_in      = time_ff;
      ch_in        = ch_ff;
      last_time_in = last_time_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      res_cnt_in   = res_cnt_ff;
      res_tot_in   = res_tot_ff;
      period_in    = period_ff;
      energy_in    = energy_ff;
      power_in     = power_ff;
      fault_in     = fault_ff;
      last_in      = last_ff;
      div_start    = 1'b0;
      div_dividend = NUM_D;
      div_divisor  = TIME_BITS'(rate);
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               rise_in  = levels & ~prev_ff;
               prev_in  = levels;
               time_in  = TIME_BITS'(req_bus.sample_time);
               ch_in    = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rise_ff == '0) begin
               state_in = ST_IDLE;
            end else if (rise_ff[ch_ff]) begin
               period_in           = time_ff - last_time_ff[ch_ff];
               last_time_in[ch_ff] = time_ff;
               count_in[ch_ff]     = cnt_next;
               total_in            = tot_next;
               res_cnt_in          = cnt_next;
               res_tot_in          = tot_next;
               rise_in             = rise_clr;
               last_in             = (rise_clr == '0);
               state_in            = ST_ENERGY;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end
         ST_ENERGY: begin
            if (rate == '0) begin
               energy_in = mpem_pkg::SAT;
               power_in  = mpem_pkg::SAT;
               fault_in  = 1'b1;
               state_in  = ST_OUT;
            end else begin
               fault_in     = 1'b0;
               div_start    = 1'b1;
               div_dividend = DIVW'(prod);
               state_in     = ST_WAIT_E;
            end
         end
         ST_WAIT_E: begin
            if (div_done) begin
               energy_in = div_sat;
               div_start = 1'b1;
               state_in  = ST_WAIT_N;
            end
         end
         ST_WAIT_N: begin
            if (div_done) begin
               if (period_ff == '0) begin
                  power_in = mpem_pkg::SAT;
                  fault_in = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  // second stage of power: (NUM / rate) / period
                  div_start    = 1'b1;
                  div_dividend = div_quo;
                  div_divisor  = period_ff;
                  state_in     = ST_WAIT_P;
               end
            end
         end
         ST_WAIT_P: begin
            if (div_done) begin
               power_in = div_sat;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_bus.ready) begin
               state_in = last_ff ? ST_IDLE : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prev_ff  <= '0;
         total_ff <= '0;
         for (int i = 0; i < NCH; i++) begin
            last_time_ff[i] <= '0;
            count_ff[i]     <= '0;
         end
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         total_ff     <= total_in;
         last_time_ff <= last_time_in;
         count_ff     <= count_in;
      end
      rise_ff    <= rise_in;
      time_ff    <= time_in;
      ch_ff      <= ch_in;
      res_cnt_ff <= res_cnt_in;
      res_tot_ff <= res_tot_in;
      period_ff  <= period_in;
      energy_ff  <= energy_in;
      power_ff   <= power_in;
      fault_ff   <= fault_in;
      last_ff    <= last_in;
   end

   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign rsp_bus.valid          = (state_ff == ST_OUT);
   assign rsp_bus.channel        = ch_ff;
   assign rsp_bus.pulse_count    = OW'(res_cnt_ff);
   assign rsp_bus.period_ticks   = mpem_pkg::STAMP_W'(period_ff);
   assign rsp_bus.energy_wh      = energy_ff;
   assign rsp_bus.power_w        = power_ff;
   assign rsp_bus.total_pulses   = OW'(res_tot_ff);
   assign rsp_bus.divide_fault   = fault_ff;
   assign rsp_bus.last_of_sample = last_ff;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !req_bus.ready)
      else $error("sample taken while a result is pending");

   a_fault_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.divide_fault) |-> (rsp_bus.power_w == mpem_pkg::SAT))
      else $error("fault result without saturated power");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && rsp_bus.last_of_sample) |=> req_bus.ready)
      else $error("not ready after final result of a sample");

endmodule
